// ----- hdl/bpq_pkg.sv -----
package bpq_pkg;

   localparam int DEPTH_DEF        = 16;
   localparam int PAYLOAD_BITS_DEF = 16;
   localparam int PRIO_BITS_DEF    = 8;

   localparam int CAP_W      = 5;
   localparam int CFG_DW     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int OPCODE_W   = 3;
   localparam int CNT_OUT_W  = 5;

   localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
   localparam logic [CFG_DW-1:0] DPRIO_RESET = 8'd0;

   typedef enum logic [OPCODE_W-1:0] {
      OP_APPEND  = 3'd0,
      OP_INSERT  = 3'd1,
      OP_DEQUEUE = 3'd2,
      OP_PEEK    = 3'd3,
      OP_CLEAR   = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAPACITY     = 2'd0,
      CSR_DEFAULT_PRIO = 2'd1
   } csr_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic insert;
      logic force_ge;
   } cell_ctl_type;

endpackage

// ----- hdl/bpq_cell.sv -----
module bpq_cell #(
   parameter int PAYLOAD_BITS = bpq_pkg::PAYLOAD_BITS_DEF,
   parameter int PRIO_BITS    = bpq_pkg::PRIO_BITS_DEF,
   parameter int CNT_W        = 5,
   parameter int INDEX        = 0
) (
   input  logic                     clock,
   input  bpq_pkg::cell_ctl_type    ctl,
   input  logic [PAYLOAD_BITS-1:0]  new_payload,
   input  logic [PRIO_BITS-1:0]     new_prio,
   input  logic [CNT_W-1:0]         count,
   input  logic [PAYLOAD_BITS-1:0]  left_payload,
   input  logic [PRIO_BITS-1:0]     left_prio,
   input  logic                     found_in,
   input  logic [PAYLOAD_BITS-1:0]  right_payload,
   input  logic [PRIO_BITS-1:0]     right_prio,
   input  logic                     right_ge,
   output logic                     ge_out,
   output logic                     found_out,
   output logic [PAYLOAD_BITS-1:0]  payload_out,
   output logic [PRIO_BITS-1:0]     prio_out
);

   logic [PAYLOAD_BITS-1:0] payload_ff, payload_in;
   logic [PRIO_BITS-1:0]    prio_ff, prio_in;
   logic                    occupied;
   logic                    ge_view;
   logic                    ins_here;

   assign occupied    = CNT_W'(INDEX) < count;
   assign ge_out      = occupied && (ctl.force_ge || prio_ff >= new_prio);
   // ge flag of the entry that lands here once the head is gone
   assign ge_view     = ctl.shift ? right_ge : ge_out;
   assign found_out   = found_in || !ge_view;
   assign ins_here    = ctl.insert && !found_in && !ge_view;
   assign payload_out = payload_ff;
   assign prio_out    = prio_ff;

   always_comb begin
      if (ctl.insert && found_in) begin
         payload_in = ctl.shift ? payload_ff : left_payload;
         prio_in    = ctl.shift ? prio_ff : left_prio;
      end else if (ins_here) begin
         payload_in = new_payload;
         prio_in    = new_prio;
      end else begin
         payload_in = ctl.shift ? right_payload : payload_ff;
         prio_in    = ctl.shift ? right_prio : prio_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         payload_ff <= payload_in;
         prio_ff    <= prio_in;
      end
   end

endmodule

// ----- hdl/bounded_priority_queue_drop_head.sv -----
// each response is registered and presented in the cycle after its request is accepted
// one request per cycle unless an untaken response stalls it; every operation finishes in a single step
// set by the row of DEPTH cells that shift, compare and insert in parallel
// reset clears the entry count, capacity to 16 and default priority to 0
// entry storage is not cleared and needs no clearing pass
module bounded_priority_queue_drop_head #(
   parameter int DEPTH        = bpq_pkg::DEPTH_DEF,
   parameter int PAYLOAD_BITS = bpq_pkg::PAYLOAD_BITS_DEF,
   parameter int PRIO_BITS    = bpq_pkg::PRIO_BITS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   // payload, prio
   input  logic [((PAYLOAD_BITS+PRIO_BITS+7)/8)*8-1:0] req_tdata,
   // opcode
   input  logic [bpq_pkg::OPCODE_W-1:0]              req_tuser,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   // out_valid, out_data, out_prio, dropped, dropped_data, entry_count, is_full, is_empty
   output logic [((2*PAYLOAD_BITS+PRIO_BITS+9+7)/8)*8-1:0] rsp_tdata,
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [bpq_pkg::CSR_IDX_W-1:0]             csr_index,
   input  logic [bpq_pkg::CFG_DW-1:0]                csr_data
);

   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int RSP_BITS = 2 * PAYLOAD_BITS + PRIO_BITS + 9;
   localparam int RSP_DW   = ((RSP_BITS + 7) / 8) * 8;

   logic [CNT_W-1:0]               count_ff, count_in;
   logic [bpq_pkg::CAP_W-1:0]      cap_ff;
   logic [bpq_pkg::CFG_DW-1:0]     dprio_ff;
   logic                           rsp_valid_ff;
   logic [RSP_DW-1:0]              rsp_tdata_ff, rsp_tdata_in;

   logic                           req_fire;
   logic [CNT_W-1:0]               cap_eff;
   logic                           full_now;
   logic [PAYLOAD_BITS-1:0]        req_payload;
   logic [PRIO_BITS-1:0]           req_prio;
   logic [PRIO_BITS-1:0]           new_prio;
   bpq_pkg::cell_ctl_type          ctl;
   logic                           out_valid, dropped;
   logic [PAYLOAD_BITS-1:0]        out_data, dropped_data;
   logic [PRIO_BITS-1:0]           out_prio;

   logic [PAYLOAD_BITS-1:0]        cell_payload [DEPTH];
   logic [PRIO_BITS-1:0]           cell_prio    [DEPTH];
   logic                           cell_ge      [DEPTH];
   logic                           cell_found   [DEPTH];

   assign req_tready  = !rsp_valid_ff || rsp_tready;
   assign req_fire    = req_tvalid && req_tready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_tdata_ff;
   assign csr_ready   = 1'b1;
   assign req_payload = req_tdata[PAYLOAD_BITS-1:0];
   assign req_prio    = req_tdata[PAYLOAD_BITS +: PRIO_BITS];

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_W'(1);
      end else if (32'(cap_ff) > 32'(DEPTH)) begin
         cap_eff = CNT_W'(DEPTH);
      end else begin
         cap_eff = CNT_W'(cap_ff);
      end
   end

   assign full_now = count_ff >= cap_eff;

   always_comb begin
      ctl          = '0;
      ctl.load     = req_fire;
      new_prio     = req_prio;
      count_in     = count_ff;
      out_valid    = 1'b0;
      out_data     = '0;
      out_prio     = '0;
      dropped      = 1'b0;
      dropped_data = '0;
      case (req_tuser)
         bpq_pkg::OP_APPEND, bpq_pkg::OP_INSERT: begin
            dropped      = full_now && (count_ff != '0);
            dropped_data = dropped ? cell_payload[0] : '0;
            ctl.shift    = dropped;
            ctl.insert   = 1'b1;
            ctl.force_ge = (req_tuser == bpq_pkg::OP_APPEND);
            if (req_tuser == bpq_pkg::OP_APPEND) begin
               new_prio = PRIO_BITS'(dprio_ff);
            end
            count_in = dropped ? count_ff : count_ff + 1'b1;
         end
         bpq_pkg::OP_DEQUEUE, bpq_pkg::OP_PEEK: begin
            if (count_ff != '0) begin
               out_valid = 1'b1;
               out_data  = cell_payload[0];
               out_prio  = cell_prio[0];
               if (req_tuser == bpq_pkg::OP_DEQUEUE) begin
                  ctl.shift = 1'b1;
                  count_in  = count_ff - 1'b1;
               end
            end
         end
         bpq_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
         end
      endcase
      rsp_tdata_in = RSP_DW'({(count_in == '0), (count_in >= cap_eff),
                              bpq_pkg::CNT_OUT_W'(count_in), dropped_data, dropped,
                              out_prio, out_data, out_valid});
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [PAYLOAD_BITS-1:0] left_payload, right_payload;
      logic [PRIO_BITS-1:0]    left_prio, right_prio;
      logic                    found_in, right_ge;

      if (i == 0) begin : g_first
         assign left_payload = '0;
         assign left_prio    = '0;
         assign found_in     = 1'b0;
      end else begin : g_mid
         assign left_payload = cell_payload[i-1];
         assign left_prio    = cell_prio[i-1];
         assign found_in     = cell_found[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_payload = '0;
         assign right_prio    = '0;
         assign right_ge      = 1'b0;
      end else begin : g_inner
         assign right_payload = cell_payload[i+1];
         assign right_prio    = cell_prio[i+1];
         assign right_ge      = cell_ge[i+1];
      end

      bpq_cell #(
         .PAYLOAD_BITS (PAYLOAD_BITS),
         .PRIO_BITS    (PRIO_BITS),
         .CNT_W        (CNT_W),
         .INDEX        (i)
      ) u_cell (
         .clock         (clock),
         .ctl           (ctl),
         .new_payload   (req_payload),
         .new_prio      (new_prio),
         .count         (count_ff),
         .left_payload  (left_payload),
         .left_prio     (left_prio),
         .found_in      (found_in),
         .right_payload (right_payload),
         .right_prio    (right_prio),
         .right_ge      (right_ge),
         .ge_out        (cell_ge[i]),
         .found_out     (cell_found[i]),
         .payload_out   (cell_payload[i]),
         .prio_out      (cell_prio[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= bpq_pkg::CAP_RESET;
         dprio_ff     <= bpq_pkg::DPRIO_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bpq_pkg::CSR_CAPACITY:     cap_ff   <= csr_data[bpq_pkg::CAP_W-1:0];
               bpq_pkg::CSR_DEFAULT_PRIO: dprio_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= 32'(DEPTH))
      else $error("entry count above depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == bpq_pkg::OP_CLEAR) |=> (count_ff == '0))
      else $error("clear left entries behind");

   a_enq_nonempty: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == bpq_pkg::OP_APPEND || req_tuser == bpq_pkg::OP_INSERT))
      |=> (count_ff != '0))
      else $error("enqueue left queue empty");

   a_drop_only_full: assert property (@(posedge clock) disable iff (reset)
      (req_fire && dropped) |-> (count_ff >= cap_eff))
      else $error("head dropped below capacity");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

   localparam int REQ_W       = ((bpq_pkg::PAYLOAD_BITS_DEF + bpq_pkg::PRIO_BITS_DEF + 7) / 8)
                                * 8;
   localparam int RSP_W       = ((2 * bpq_pkg::PAYLOAD_BITS_DEF + bpq_pkg::PRIO_BITS_DEF + 9
                                  + 7) / 8) * 8;
   localparam int LATENCY     = 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 105;

   // fields from the highest bit down, so the last member sits at bit 0
   typedef struct packed {
      logic                                 is_empty;
      logic                                 is_full;
      logic [bpq_pkg::CNT_OUT_W-1:0]        entry_count;
      logic [bpq_pkg::PAYLOAD_BITS_DEF-1:0] dropped_data;
      logic                                 dropped;
      logic [bpq_pkg::PRIO_BITS_DEF-1:0]    out_prio;
      logic [bpq_pkg::PAYLOAD_BITS_DEF-1:0] out_data;
      logic                                 out_valid;
   } bpq_result_type;

   localparam int RES_W = $bits(bpq_result_type);

   logic                          clock;
   logic                          reset;
   logic                          req_tvalid;
   logic                          req_tready;
   // payload, prio
   logic [REQ_W-1:0]              req_tdata;
   // opcode
   logic [bpq_pkg::OPCODE_W-1:0]  req_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready;
   // out_valid, out_data, out_prio, dropped, dropped_data, entry_count, is_full, is_empty
   logic [RSP_W-1:0]              rsp_tdata;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [bpq_pkg::CSR_IDX_W-1:0] csr_index;
   logic [bpq_pkg::CFG_DW-1:0]    csr_data;

   bpq_result_type expected_results[$];
   int             error_count;
   int             cycle_count;
   bit             idle_enabled;

   logic [bpq_pkg::PAYLOAD_BITS_DEF-1:0] model_payload [bpq_pkg::DEPTH_DEF];
   logic [bpq_pkg::PRIO_BITS_DEF-1:0]    model_prio    [bpq_pkg::DEPTH_DEF];
   int                                   model_count;
   logic [bpq_pkg::CAP_W-1:0]            model_capacity;
   logic [bpq_pkg::PRIO_BITS_DEF-1:0]    model_default_prio;

   bounded_priority_queue_drop_head u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_error($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   function automatic void pop_model_head();
      for (int i = 1; i < model_count; i++) begin
         model_payload[i-1] = model_payload[i];
         model_prio[i-1]    = model_prio[i];
      end
      if (model_count > 0) model_count--;
   endfunction

   function automatic bpq_result_type predict_queue_op(
         input logic [bpq_pkg::OPCODE_W-1:0] op,
         input logic [bpq_pkg::PAYLOAD_BITS_DEF-1:0] pl,
         input logic [bpq_pkg::PRIO_BITS_DEF-1:0] pr);
      bpq_result_type                    res;
      int                                cap;
      int                                pos;
      logic [bpq_pkg::PRIO_BITS_DEF-1:0] new_prio;
      res = '0;
      cap = int'(model_capacity);
      if (cap < 1) cap = 1;
      if (cap > bpq_pkg::DEPTH_DEF) cap = bpq_pkg::DEPTH_DEF;
      if (op == bpq_pkg::OP_APPEND || op == bpq_pkg::OP_INSERT) begin
         if (model_count >= cap && model_count > 0) begin
            res.dropped      = 1'b1;
            res.dropped_data = model_payload[0];
            pop_model_head();
         end
         if (op == bpq_pkg::OP_APPEND) begin
            new_prio = model_default_prio;
            pos      = model_count;
         end else begin
            new_prio = pr;
            pos      = 0;
            while (pos < model_count && model_prio[pos] >= pr) pos++;
         end
         if (model_count < bpq_pkg::DEPTH_DEF) begin
            for (int i = model_count; i > pos; i--) begin
               model_payload[i] = model_payload[i-1];
               model_prio[i]    = model_prio[i-1];
            end
            model_payload[pos] = pl;
            model_prio[pos]    = new_prio;
            model_count++;
         end
      end else if (op == bpq_pkg::OP_DEQUEUE || op == bpq_pkg::OP_PEEK) begin
         if (model_count > 0) begin
            res.out_valid = 1'b1;
            res.out_data  = model_payload[0];
            res.out_prio  = model_prio[0];
            if (op == bpq_pkg::OP_DEQUEUE) pop_model_head();
         end
      end else if (op == bpq_pkg::OP_CLEAR) begin
         model_count = 0;
      end
      res.entry_count = bpq_pkg::CNT_OUT_W'(model_count);
      res.is_full     = (model_count >= cap);
      res.is_empty    = (model_count == 0);
      return res;
   endfunction

   // response side backpressure
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            stall_left = $urandom_range(1, 19) - 1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : check_responses
      bpq_result_type got;
      bpq_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_error("response with no request pending");
         end else begin
            want = expected_results.pop_front();
            got  = bpq_result_type'(rsp_tdata[RES_W-1:0]);
            check_field("out_valid", 32'(got.out_valid), 32'(want.out_valid));
            check_field("out_data", 32'(got.out_data), 32'(want.out_data));
            check_field("out_prio", 32'(got.out_prio), 32'(want.out_prio));
            check_field("dropped", 32'(got.dropped), 32'(want.dropped));
            check_field("dropped_data", 32'(got.dropped_data), 32'(want.dropped_data));
            check_field("entry_count", 32'(got.entry_count), 32'(want.entry_count));
            check_field("is_full", 32'(got.is_full), 32'(want.is_full));
            check_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
         end
      end
   end

   task automatic send_request(input logic [bpq_pkg::OPCODE_W-1:0] op,
         input logic [bpq_pkg::PAYLOAD_BITS_DEF-1:0] pl,
         input logic [bpq_pkg::PRIO_BITS_DEF-1:0] pr);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_W'({pr, pl});
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(predict_queue_op(op, pl, pr));
      if (idle_enabled && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 19);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 1) @(posedge clock);
   endtask

   task automatic write_csr(input logic [bpq_pkg::CSR_IDX_W-1:0] idx,
                            input logic [bpq_pkg::CFG_DW-1:0] val);
      drain_requests();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == bpq_pkg::CSR_CAPACITY) model_capacity = val[bpq_pkg::CAP_W-1:0];
      else if (idx == bpq_pkg::CSR_DEFAULT_PRIO) model_default_prio = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_empty_queue();
      send_request(bpq_pkg::OP_PEEK, 16'hFFFF, 8'hFF);
      send_request(bpq_pkg::OP_DEQUEUE, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_service_order();
      send_request(bpq_pkg::OP_APPEND, 16'h0000, 8'hFF);
      send_request(bpq_pkg::OP_INSERT, 16'hFFFF, 8'hFF);
      send_request(bpq_pkg::OP_INSERT, 16'h1111, 8'hFF);
      send_request(bpq_pkg::OP_INSERT, 16'h2222, 8'h00);
      send_request(bpq_pkg::OP_APPEND, 16'h3333, 8'h80);
      send_request(bpq_pkg::OP_PEEK, 16'($urandom), 8'($urandom));
      for (int k = int'(bpq_pkg::OP_CLEAR) + 1; k < (1 << bpq_pkg::OPCODE_W); k++)
         send_request(bpq_pkg::OPCODE_W'(k), 16'($urandom), 8'($urandom));
      repeat (6) send_request(bpq_pkg::OP_DEQUEUE, 16'($urandom), 8'($urandom));
      send_request(bpq_pkg::OP_APPEND, 16'hBEEF, 8'h00);
      send_request(bpq_pkg::OP_CLEAR, 16'hFFFF, 8'hFF);
   endtask

   task automatic test_capacity_limits();
      write_csr(bpq_pkg::CSR_CAPACITY, 8'd0);
      write_csr(bpq_pkg::CSR_DEFAULT_PRIO, 8'hFF);
      send_request(bpq_pkg::OP_APPEND, 16'hA5A5, 8'h00);
      send_request(bpq_pkg::OP_APPEND, 16'h5A5A, 8'h00);
      send_request(bpq_pkg::OP_INSERT, 16'hC3C3, 8'h00);
      // unmapped registers
      for (int k = int'(bpq_pkg::CSR_DEFAULT_PRIO) + 1; k < (1 << bpq_pkg::CSR_IDX_W); k++)
         write_csr(bpq_pkg::CSR_IDX_W'(k), 8'($urandom));
      write_csr(bpq_pkg::CSR_CAPACITY, 8'hFF);
      repeat (3) send_request(bpq_pkg::OP_APPEND, 16'($urandom), 8'($urandom));
      // capacity below the held count
      write_csr(bpq_pkg::CSR_CAPACITY, 8'd2);
      send_request(bpq_pkg::OP_INSERT, 16'h0F0F, 8'hFF);
      send_request(bpq_pkg::OP_APPEND, 16'hF0F0, 8'h00);
      send_request(bpq_pkg::OP_PEEK, 16'h0000, 8'h00);
      send_request(bpq_pkg::OP_CLEAR, 16'h0000, 8'h00);
   endtask

   task automatic test_random_traffic();
      logic [bpq_pkg::CFG_DW-1:0]        cap;
      logic [bpq_pkg::CFG_DW-1:0]        dprio;
      logic [bpq_pkg::OPCODE_W-1:0]      op;
      logic [bpq_pkg::PRIO_BITS_DEF-1:0] pr;
      int                                enq_weight;
      int                                r;
      for (int phase = 0; phase < PHASES; phase++) begin
         dprio = 8'($urandom);
         case (phase)
            0: begin
               cap   = bpq_pkg::CFG_DW'(bpq_pkg::CAP_RESET);
               dprio = 8'h00;
            end
            1: begin
               cap   = 8'd1;
               dprio = 8'hFF;
            end
            2: cap = 8'd0;
            3: cap = 8'($urandom_range(bpq_pkg::DEPTH_DEF + 1, 255));
            4: cap = 8'($urandom_range(2, bpq_pkg::DEPTH_DEF - 1));
            default: cap = 8'($urandom_range(1, bpq_pkg::DEPTH_DEF));
         endcase
         write_csr(bpq_pkg::CSR_CAPACITY, cap);
         write_csr(bpq_pkg::CSR_DEFAULT_PRIO, dprio);
         idle_enabled = (phase != 2) && (phase < PHASES - 1);
         enq_weight   = 50 + $urandom_range(0, 25);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < enq_weight)
               op = ($urandom_range(0, 9) < 6) ? bpq_pkg::OP_INSERT : bpq_pkg::OP_APPEND;
            else if (r < 88)
               op = ($urandom_range(0, 3) == 0) ? bpq_pkg::OP_PEEK : bpq_pkg::OP_DEQUEUE;
            else if (r < 92)
               op = bpq_pkg::OP_CLEAR;
            else
               op = bpq_pkg::OPCODE_W'($urandom_range(int'(bpq_pkg::OP_CLEAR) + 1,
                                                      (1 << bpq_pkg::OPCODE_W) - 1));
            // favor a few levels so ties are common
            case ($urandom_range(0, 3))
               0: pr = 8'($urandom);
               1: pr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
               2: pr = model_default_prio;
               default: pr = 8'($urandom_range(0, 3) * 85);
            endcase
            send_request(op, 16'($urandom), pr);
         end
      end
   endtask

   initial begin
      int wait_cycles;
      reset              = 1'b1;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      req_tuser          = '0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      idle_enabled       = 1'b0;
      error_count        = 0;
      cycle_count        = 0;
      model_count        = 0;
      model_capacity     = bpq_pkg::CAP_RESET;
      model_default_prio = bpq_pkg::DPRIO_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_service_order();
      test_capacity_limits();
      test_random_traffic();

      @(negedge clock);
      req_tvalid <= 1'b0;
      wait_cycles = 0;
      while (expected_results.size() != 0 && wait_cycles < 1000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (LATENCY + 2) @(posedge clock);
      if (expected_results.size() != 0)
         report_error($sformatf("%0d responses never arrived", expected_results.size()));
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
